FILE: src/oii_pkg.sv
// Shared constants and types for the obstacle integral image block.
package oii_pkg;

  localparam int CHAR_W      = 8;
  localparam int ROW_WIDTH_W = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CHAR_W-1:0]      EMPTY_CHAR_RESET    = 8'd46;
  localparam logic [CHAR_W-1:0]      OBSTACLE_CHAR_RESET = 8'd111;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET     = 11'd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_EMPTY_CHAR    = 2'd0,
    CFG_OBSTACLE_CHAR = 2'd1,
    CFG_ROW_WIDTH     = 2'd2
  } cfg_reg_t;

  // Per-cell flags handed from the scan stage to the accumulate stage.
  typedef struct packed {
    logic first_row;
    logic unknown;
  } cell_flags_t;

endpackage

FILE: src/oii_if.sv
// Valid/ready channel interfaces for the cell input and the total output.
interface oii_cell_if;
  logic                          valid;
  logic                          ready;
  logic [oii_pkg::CHAR_W-1:0]    cell_char;
  logic                          start_of_frame;

  modport source (output valid, output cell_char, output start_of_frame, input ready);
  modport sink   (input valid, input cell_char, input start_of_frame, output ready);
endinterface

interface oii_total_if #(
  parameter int TOTAL_WIDTH = 21
);
  logic                   valid;
  logic                   ready;
  logic [TOTAL_WIDTH-1:0] obstacle_total;
  logic                   unknown_char;

  modport source (output valid, output obstacle_total, output unknown_char, input ready);
  modport sink   (input valid, input obstacle_total, input unknown_char, output ready);
endinterface

FILE: src/obstacle_integral_image.sv
// Streaming summed-area table of obstacle cells in a character map.
//
// Cells arrive in raster order, one word per cycle, and each yields one
// result word: the count of obstacle cells from the map origin to that cell,
// saturating at all ones, plus a flag for characters that match neither the
// empty nor the obstacle code. The block sustains one cell per cycle unless
// total_out.ready stalls it. A cell is registered in the accumulate stage
// alongside the line buffer's registered read of the row above; a saturating
// add feeds the output register. Assert start_of_frame on the first cell
// of each map; raising row_width mid-map without a new frame reads stale
// line-buffer entries. Configuration writes belong in idle periods only.
module obstacle_integral_image #(
  parameter int MAX_COLS    = 1024,
  parameter int TOTAL_WIDTH = 21
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [oii_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [oii_pkg::CFG_DATA_W-1:0]  cfg_data,
  oii_cell_if.sink                        cell_in,
  oii_total_if.source                     total_out
);

  localparam int COL_W = $clog2(MAX_COLS);

  logic                   accept, s1_advance;
  logic [COL_W-1:0]       item_col;
  logic [TOTAL_WIDTH-1:0] item_sum;
  oii_pkg::cell_flags_t   item_flags;

  logic                   s1_valid;
  logic [COL_W-1:0]       s1_col;
  logic [TOTAL_WIDTH-1:0] s1_sum;
  oii_pkg::cell_flags_t   s1_flags;

  logic [TOTAL_WIDTH-1:0] above_raw, above;
  logic [TOTAL_WIDTH:0]   total_wide;
  logic [TOTAL_WIDTH-1:0] total;

  logic                   out_valid;
  logic [TOTAL_WIDTH-1:0] out_total;
  logic                   out_unknown;

  // Advance the accumulate stage whenever the output register frees up.
  assign s1_advance    = s1_valid && (!out_valid || total_out.ready);
  assign cell_in.ready = !s1_valid || s1_advance;
  assign accept        = cell_in.valid && cell_in.ready;

  oii_scan #(
    .MAX_COLS    (MAX_COLS),
    .TOTAL_WIDTH (TOTAL_WIDTH),
    .COL_W       (COL_W)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .cell_char      (cell_in.cell_char),
    .start_of_frame (cell_in.start_of_frame),
    .item_col       (item_col),
    .item_sum       (item_sum),
    .item_flags     (item_flags)
  );

  oii_linebuf #(
    .DEPTH  (MAX_COLS),
    .DATA_W (TOTAL_WIDTH),
    .ADDR_W (COL_W)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (item_col),
    .rd_data (above_raw),
    .wr_en   (s1_advance),
    .wr_addr (s1_col),
    .wr_data (total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= item_col;
      s1_sum   <= item_sum;
      s1_flags <= item_flags;
    end
  end

  // The first row sees zeros from above; clamp the sum on carry out.
  always_comb begin
    above      = s1_flags.first_row ? '0 : above_raw;
    total_wide = {1'b0, above} + {1'b0, s1_sum};
    total      = total_wide[TOTAL_WIDTH] ? '1 : total_wide[TOTAL_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (total_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_total   <= total;
      out_unknown <= s1_flags.unknown;
    end
  end

  assign total_out.valid          = out_valid;
  assign total_out.obstacle_total = out_total;
  assign total_out.unknown_char   = out_unknown;

endmodule

FILE: src/oii_linebuf.sv
// Line buffer of previous-row totals with same-cycle write forwarding.
module oii_linebuf #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 21,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic [DATA_W-1:0] fwd_data;
  logic              fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Catch a write landing on the entry being read at the same edge.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

FILE: src/oii_scan.sv
// Configuration registers, cell classification and row/column tracking.
module oii_scan #(
  parameter int MAX_COLS    = 1024,
  parameter int TOTAL_WIDTH = 21,
  parameter int COL_W       = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [oii_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [oii_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  logic [oii_pkg::CHAR_W-1:0]      cell_char,
  input  logic                            start_of_frame,
  output logic [COL_W-1:0]                item_col,
  output logic [TOTAL_WIDTH-1:0]          item_sum,
  output oii_pkg::cell_flags_t            item_flags
);

  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int EW    = (CNT_W > oii_pkg::ROW_WIDTH_W) ? CNT_W : oii_pkg::ROW_WIDTH_W;
  localparam logic [EW-1:0]          MAX_W   = EW'(MAX_COLS);
  localparam logic [TOTAL_WIDTH-1:0] SUM_MAX = '1;

  logic [oii_pkg::CHAR_W-1:0]      empty_char;
  logic [oii_pkg::CHAR_W-1:0]      obstacle_char;
  logic [oii_pkg::ROW_WIDTH_W-1:0] row_width;

  logic [COL_W-1:0]       column_index, column_index_next;
  logic [TOTAL_WIDTH-1:0] row_running_sum, row_running_sum_next;
  logic                   in_first_row, in_first_row_next;

  logic [EW-1:0]          rw_ext, eff_width, col_inc;
  logic                   wrap, restart, is_empty, is_obstacle;
  logic [TOTAL_WIDTH-1:0] base_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_char    <= oii_pkg::EMPTY_CHAR_RESET;
      obstacle_char <= oii_pkg::OBSTACLE_CHAR_RESET;
      row_width     <= oii_pkg::ROW_WIDTH_RESET;
    end else if (cfg_write) begin
      unique case (oii_pkg::cfg_reg_t'(cfg_index))
        oii_pkg::CFG_EMPTY_CHAR:    empty_char    <= cfg_data[oii_pkg::CHAR_W-1:0];
        oii_pkg::CFG_OBSTACLE_CHAR: obstacle_char <= cfg_data[oii_pkg::CHAR_W-1:0];
        oii_pkg::CFG_ROW_WIDTH:     row_width     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the row width into 1..MAX_COLS.
  always_comb begin
    rw_ext = EW'(row_width);
    if (rw_ext == '0) begin
      eff_width = EW'(1);
    end else if (rw_ext > MAX_W) begin
      eff_width = MAX_W;
    end else begin
      eff_width = rw_ext;
    end
  end

  always_comb begin
    wrap    = EW'(column_index) >= eff_width;
    restart = start_of_frame || wrap;

    item_col = restart ? '0 : column_index;
    base_sum = restart ? '0 : row_running_sum;
    item_flags.first_row = start_of_frame ? 1'b1 : (wrap ? 1'b0 : in_first_row);

    // Empty match wins when both codes are the same.
    is_empty    = cell_char == empty_char;
    is_obstacle = !is_empty && (cell_char == obstacle_char);
    item_flags.unknown = !is_empty && !is_obstacle;

    item_sum = (is_obstacle && (base_sum != SUM_MAX)) ? base_sum + 1'b1 : base_sum;

    col_inc = EW'(item_col) + 1'b1;
    if (col_inc >= eff_width) begin
      column_index_next    = '0;
      row_running_sum_next = '0;
      in_first_row_next    = 1'b0;
    end else begin
      column_index_next    = col_inc[COL_W-1:0];
      row_running_sum_next = item_sum;
      in_first_row_next    = item_flags.first_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index    <= '0;
      row_running_sum <= '0;
      in_first_row    <= 1'b1;
    end else if (accept) begin
      column_index    <= column_index_next;
      row_running_sum <= row_running_sum_next;
      in_first_row    <= in_first_row_next;
    end
  end

endmodule
